>>> sv/assert_macros.svh
// assertion macros used by the prefix table unit
// needs clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// plain invariant
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`endif

>>> sv/vipt_pkg.sv
// types and constants of the vrf ipv4 prefix table
// no dependencies
`default_nettype none
package vipt_pkg;
  localparam int VRF_COUNT   = 256;
  localparam int POOL_BLOCKS = 1024;
  localparam int IDX_W       = $clog2(POOL_BLOCKS);
  localparam int HEAD_W      = (VRF_COUNT > 1) ? $clog2(VRF_COUNT) : 1;
  localparam int LINK_W      = 11;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_VRF   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic              used;
    logic [LINK_W-1:0] link;
    logic [5:0]        len;
    logic [31:0]       prefix;
    logic [31:0]       value;
  } entry_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) m = 32'd0;
    else if (len >= 6'd32) m = 32'hFFFF_FFFF;
    else m = ~((32'd1 << (6'd32 - len)) - 32'd1);
    return m;
  endfunction
endpackage
`default_nettype wire

>>> sv/vipt_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module vipt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/vrf_ipv4_prefix_table_unit.sv
// walks the vrf chain one entry at a time, and an append then fills a fresh block in S_WR2
// a bad vrf or mode 3 skips the walk; one item at a time; one entry memory read per cycle
// result sits in an output register, a new item is taken once the result has moved there
// reset: synchronous active low; clears head-valid flags, allocation mark and control
// no clearing pass: unwritten heads read as unused with a null link
`default_nettype none
`include "assert_macros.svh"
module vrf_ipv4_prefix_table_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_vrf_id,
  input  wire logic [31:0] in_ip_address,
  input  wire logic [5:0]  in_prefix_len,
  input  wire logic [31:0] in_route_value,
  input  wire logic        in_last_of_batch,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_found,
  output logic [31:0]      out_match_value,
  output logic             out_batch_end
);
  import vipt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXAM = 2'd1;
  localparam logic [1:0] S_WR2  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int EW = $bits(entry_t);

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        mode_r;
  logic [31:0]       ip_r, val_r;
  logic [5:0]        len_r;
  logic              batch_r;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [5:0]        best_r, best_nxt;
  logic              found_r, found_nxt;
  logic [31:0]       value_r, value_nxt;
  logic              hu_r, hu_nxt;
  logic [IDX_W-1:0]  us_r, us_nxt;
  logic [LINK_W-1:0] ul_r, ul_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [LINK_W-1:0] nfb_r, nfb_nxt;
  logic [VRF_COUNT-1:0] head_init_r;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rd, w;
  logic [EW-1:0]    rdata;

  vipt_ram #(.WIDTH(EW), .DEPTH(POOL_BLOCKS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd = entry_t'(rdata);

  logic is_head, chain_end, match, hit;
  always_comb begin
    is_head = cur_r < IDX_W'(VRF_COUNT);
    w = rd;
    // a head never written reads as unused with a null link
    if (is_head && !head_init_r[cur_r[HEAD_W-1:0]]) begin
      w.used = 1'b0;
      w.link = '0;
    end
    chain_end = (w.link == '0) || (w.link >= LINK_W'(POOL_BLOCKS));
    match = (w.prefix == ip_r) && (w.len == len_r);
    hit = w.used && (w.len >= best_r) && ((ip_r & prefix_mask(w.len)) == w.prefix);
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    best_nxt   = best_r;
    found_nxt  = found_r;
    value_nxt  = value_r;
    hu_nxt     = hu_r;
    us_nxt     = us_r;
    ul_nxt     = ul_r;
    status_nxt = status_r;
    nfb_nxt    = nfb_r;
    we         = 1'b0;
    waddr      = cur_r;
    wdata      = w;
    raddr      = w.link[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        raddr = in_vrf_id[IDX_W-1:0];
        if (in_valid) begin
          cur_nxt    = in_vrf_id[IDX_W-1:0];
          best_nxt   = '0;
          found_nxt  = 1'b0;
          value_nxt  = '0;
          hu_nxt     = 1'b0;
          status_nxt = ST_OK;
          if (in_mode == MODE_NONE) state_nxt = S_DONE;
          else if (in_vrf_id >= 16'(VRF_COUNT)) begin
            status_nxt = ST_BAD_VRF;
            state_nxt  = S_DONE;
          end else state_nxt = S_EXAM;
        end
      end
      S_EXAM: begin
        cur_nxt = w.link[IDX_W-1:0];
        case (mode_r)
          MODE_LOOKUP: begin
            if (hit) begin
              found_nxt = 1'b1;
              value_nxt = w.value;
              best_nxt  = w.len;
            end
            if (chain_end) state_nxt = S_DONE;
          end
          MODE_REMOVE: begin
            if (match) begin
              we = 1'b1;
              wdata.used = 1'b0;
              state_nxt = S_DONE;
            end else if (chain_end) state_nxt = S_DONE;
          end
          default: begin
            if (match) begin
              we = 1'b1;
              wdata.used  = 1'b1;
              wdata.value = val_r;
              state_nxt = S_DONE;
            end else begin
              if (!hu_r && !w.used) begin
                hu_nxt = 1'b1;
                us_nxt = cur_r;
                ul_nxt = w.link;
              end
              if (chain_end) begin
                state_nxt = S_DONE;
                if (hu_nxt) begin
                  we    = 1'b1;
                  waddr = us_nxt;
                  wdata = '{used: 1'b1, link: ul_nxt, len: len_r, prefix: ip_r,
                            value: val_r};
                end else if (nfb_r >= LINK_W'(POOL_BLOCKS)) begin
                  status_nxt = ST_EXHAUSTED;
                end else begin
                  // link the tail to the fresh block, then fill it
                  we = 1'b1;
                  wdata.link = nfb_r;
                  state_nxt = S_WR2;
                end
              end
            end
          end
        endcase
      end
      S_WR2: begin
        we        = 1'b1;
        waddr     = nfb_r[IDX_W-1:0];
        wdata     = '{used: 1'b1, link: '0, len: len_r, prefix: ip_r, value: val_r};
        nfb_nxt   = nfb_r + LINK_W'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nfb_r       <= LINK_W'(VRF_COUNT);
      head_init_r <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nfb_r   <= nfb_nxt;
      if (we && (waddr < IDX_W'(VRF_COUNT))) head_init_r[waddr[HEAD_W-1:0]] <= 1'b1;
      if (state_r == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    best_r   <= best_nxt;
    found_r  <= found_nxt;
    value_r  <= value_nxt;
    hu_r     <= hu_nxt;
    us_r     <= us_nxt;
    ul_r     <= ul_nxt;
    status_r <= status_nxt;
    if (state_r == S_IDLE && in_valid) begin
      mode_r  <= in_mode;
      ip_r    <= in_ip_address;
      len_r   <= in_prefix_len;
      val_r   <= in_route_value;
      batch_r <= in_last_of_batch;
    end
    if (state_r == S_DONE && (!out_valid || out_ready)) begin
      out_status      <= status_r;
      out_found       <= found_r;
      out_match_value <= value_r;
      out_batch_end   <= batch_r;
    end
  end

  `ASSERT_ALWAYS(a_nfb_bound, nfb_r <= LINK_W'(POOL_BLOCKS))
  `ASSERT_IMPL(a_write_below_mark, we, ({1'b0, waddr} <= nfb_r) || (waddr < IDX_W'(VRF_COUNT)))
  `ASSERT_IMPL(a_exhausted_full, out_valid && out_status == ST_EXHAUSTED,
               nfb_r == LINK_W'(POOL_BLOCKS))
  `ASSERT_IMPL(a_no_write_idle, state_r == S_IDLE || state_r == S_DONE, !we)
endmodule
`default_nettype wire
